@@ sv/smad_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the sliding median absolute deviation block
// no dependencies

package smad_pkg;

   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // window_size register and deviation sum field
   localparam int CFG_W = 7;
   localparam int DEV_W = 22;

   // apb-style register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CFG_W-1:0]        WINDOW_SIZE_RST = 7'd1;
   localparam logic [CSR_ADDR_W-3:0]   REG_WINDOW_SIZE = 1'b0;

   // cells summed together in the first adder stage
   localparam int SUM_GROUP = 8;

   typedef struct packed {
      logic take;    // item accepted this cycle
      logic evict;   // window full, oldest entry leaves
   } cell_ctl_type;

endpackage

@@ sv/smad_cell.sv @@
`timescale 1ns / 1ps
// one cell of the sorted sample chain: value, arrival age, insert and shift logic
// depends on smad_pkg

module smad_cell #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int AGE_W        = 6
) (
   input  logic                    clock,
   input  smad_pkg::cell_ctl_type  ctl,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   input  logic [AGE_W-1:0]        age_last,
   input  logic                    own_valid,
   input  logic                    del_le,
   input  logic [SAMPLE_WIDTH-1:0] nxt_val,
   input  logic [AGE_W-1:0]        nxt_age,
   input  logic                    nxt_gt,
   input  logic                    nxt_valid,
   input  logic [SAMPLE_WIDTH-1:0] prv_c_val,
   input  logic [AGE_W-1:0]        prv_c_age,
   input  logic                    prv_c_gt,
   output logic [SAMPLE_WIDTH-1:0] val,
   output logic [AGE_W-1:0]        age,
   output logic                    gt,
   output logic                    del,
   output logic [SAMPLE_WIDTH-1:0] c_val,
   output logic [AGE_W-1:0]        c_age,
   output logic                    c_gt
);
   import smad_pkg::*;

   logic [SAMPLE_WIDTH-1:0] val_ff, val_in;
   logic [AGE_W-1:0]        age_ff, age_in;
   logic                    c_valid;

   assign val = val_ff;
   assign age = age_ff;
   assign gt  = own_valid && (val_ff > sample);
   assign del = own_valid && ctl.evict && (age_ff == age_last);

   // view of the chain once the leaving entry is squeezed out
   assign c_val   = del_le ? nxt_val   : val_ff;
   assign c_age   = del_le ? nxt_age   : age_ff;
   assign c_gt    = del_le ? nxt_gt    : gt;
   assign c_valid = del_le ? nxt_valid : own_valid;

   always_comb begin
      priority if (prv_c_gt) begin
         val_in = prv_c_val;
         age_in = prv_c_age + AGE_W'(1);
      end else if (c_gt || !c_valid) begin
         val_in = sample;
         age_in = '0;
      end else begin
         val_in = c_val;
         age_in = c_age + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

endmodule

@@ sv/smad_sum.sv @@
`timescale 1ns / 1ps
// two-stage registered adder tree: median pick and deviation sum over the chain
// depends on smad_pkg

module smad_sum #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                load1,
   input  logic                                load2,
   input  logic [SAMPLE_WIDTH-1:0]             cell_val [WINDOW_MAX],
   input  logic [$clog2(WINDOW_MAX+1)-1:0]     win_len,
   output logic [smad_pkg::DEV_W-1:0]          deviation_sum,
   output logic [SAMPLE_WIDTH-1:0]             median_value
);
   import smad_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int ACC_W = SAMPLE_WIDTH + $clog2(WINDOW_MAX) + 1;
   localparam int NG    = (WINDOW_MAX + SUM_GROUP - 1) / SUM_GROUP;

   logic [CNT_W-1:0]        mid_idx;
   logic                    k_even;
   logic signed [ACC_W-1:0] term [WINDOW_MAX];
   logic signed [ACC_W-1:0] part_in [NG];
   logic signed [ACC_W-1:0] part_ff [NG];
   logic [SAMPLE_WIDTH-1:0] med_in, med1_ff, med2_ff;
   logic signed [ACC_W-1:0] total;
   logic [DEV_W-1:0]        dev_ff;

   assign mid_idx = CNT_W'((win_len - CNT_W'(1)) >> 1);
   assign k_even  = ~win_len[0];

   // entries above the median count plus, below it minus
   always_comb begin
      med_in = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         term[i] = '0;
         if (CNT_W'(i) < win_len) begin
            if (CNT_W'(i) > mid_idx) begin
               term[i] = $signed(ACC_W'(cell_val[i]));
            end else if (CNT_W'(i) < mid_idx) begin
               term[i] = -$signed(ACC_W'(cell_val[i]));
            end
         end
         if (CNT_W'(i) == mid_idx) begin
            med_in = med_in | cell_val[i];
         end
      end
   end

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         part_in[g] = '0;
         for (int j = 0; j < SUM_GROUP; j++) begin
            if (g * SUM_GROUP + j < WINDOW_MAX) begin
               part_in[g] = part_in[g] + term[g * SUM_GROUP + j];
            end
         end
      end
   end

   // even window: one more entry sits above the lower median
   always_comb begin
      total = '0;
      for (int g = 0; g < NG; g++) begin
         total = total + part_ff[g];
      end
      if (k_even) begin
         total = total - $signed(ACC_W'(med1_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         part_ff <= part_in;
         med1_ff <= med_in;
      end
      if (load2) begin
         dev_ff  <= DEV_W'(total);
         med2_ff <= med1_ff;
      end
   end

   assign deviation_sum = dev_ff;
   assign median_value  = med2_ff;

endmodule

@@ sv/sliding_median_abs_deviation.sv @@
`timescale 1ns / 1ps
// sliding-window median absolute deviation sum over a chain of sorted cells
// results pass the cell chain, the adder stage and the output register; any may stall
// one item per cycle if not stalled; the chain inserts and evicts in the same cycle
// reset (synchronous): window empty, window_size 1, no result pending
// depends on smad_pkg, smad_cell, smad_sum

module sliding_median_abs_deviation #(
   parameter int WINDOW_MAX   = smad_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = smad_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // item input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [SAMPLE_WIDTH-1:0]          req_sample,
   // result output
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [smad_pkg::DEV_W-1:0]       rsp_deviation_sum,
   output logic [SAMPLE_WIDTH-1:0]          rsp_median_value,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [smad_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [smad_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [smad_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import smad_pkg::*;

   localparam int AGE_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   // register port
   logic             csr_wr;
   logic             csr_hit;
   logic [CFG_W-1:0] win_size_ff, win_size_in;

   // window bookkeeping
   logic [CNT_W-1:0] win_len;
   logic [AGE_W-1:0] age_last;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             result_flag;
   cell_ctl_type     ctl;

   // result pipeline valids: chain, adder stage, output register
   logic pend_ff, pend_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic adv1, adv2;

   // chain wiring
   logic [SAMPLE_WIDTH-1:0] cell_val  [WINDOW_MAX];
   logic [AGE_W-1:0]        c_age_raw [WINDOW_MAX];
   logic [SAMPLE_WIDTH-1:0] c_val     [WINDOW_MAX];
   logic [AGE_W-1:0]        c_age     [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   cell_gt, cell_del, cell_valid, del_le, c_gt;

   // ---------------------------------------------------------------
   // register port: pready tied high, window_size at word 0
   // ---------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign prdata  = csr_hit ? CSR_DATA_W'(win_size_ff) : '0;

   always_comb begin
      win_size_in = win_size_ff;
      if (csr_wr && csr_hit) begin
         win_size_in = pwdata[CFG_W-1:0];
      end
   end

   // effective window length: zero reads as one, oversize saturates
   always_comb begin
      priority if (win_size_ff == '0) begin
         win_len = CNT_W'(1);
      end else if (32'(win_size_ff) > 32'(WINDOW_MAX)) begin
         win_len = CNT_W'(WINDOW_MAX);
      end else begin
         win_len = CNT_W'(win_size_ff);
      end
   end

   // oldest entry carries age k-1 once the window is full
   assign age_last = AGE_W'(win_len - CNT_W'(1));

   // ---------------------------------------------------------------
   // handshake: each stage loads when the one after it has room,
   // so the chain keeps taking items while a result waits at the output,
   // until the adder stage and the chain hold results as well
   assign adv2      = !rsp_valid_ff || rsp_ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = !pend_ff || adv1;

   assign ctl.take  = req_valid && req_ready;
   assign ctl.evict = (fill_ff >= win_len);

   // full window after this item means a result
   assign result_flag = ctl.evict || (CNT_W'(fill_ff + CNT_W'(1)) == win_len);

   always_comb begin
      fill_in      = fill_ff;
      pend_in      = pend_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;

      if (adv2) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (adv1) begin
         s1_valid_in = pend_ff;
         pend_in     = 1'b0;
      end
      if (ctl.take) begin
         pend_in = result_flag;
         if (!ctl.evict) begin
            fill_in = CNT_W'(fill_ff + CNT_W'(1));
         end
      end
      // a new window size empties the window
      if (csr_wr && csr_hit) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff  <= WINDOW_SIZE_RST;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_size_ff  <= win_size_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // sorted chain: cell i holds the i-th smallest value of the window,
   // equal values oldest first; entries below fill_ff are live
   // ---------------------------------------------------------------
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [SAMPLE_WIDTH-1:0] nxt_val;
      logic [AGE_W-1:0]        nxt_age;
      logic                    nxt_gt;
      logic                    nxt_valid;
      logic [SAMPLE_WIDTH-1:0] prv_val;
      logic [AGE_W-1:0]        prv_age;
      logic                    prv_gt;

      assign cell_valid[i] = (CNT_W'(i) < fill_ff);
      // the leaving entry sits here or further down
      assign del_le[i]     = |cell_del[i:0];

      if (i == WINDOW_MAX - 1) begin : g_top_end
         assign nxt_val   = '0;
         assign nxt_age   = '0;
         assign nxt_gt    = 1'b0;
         assign nxt_valid = 1'b0;
      end else begin : g_top_mid
         assign nxt_val   = cell_val[i+1];
         assign nxt_age   = c_age_raw[i+1];
         assign nxt_gt    = cell_gt[i+1];
         assign nxt_valid = cell_valid[i+1];
      end

      if (i == 0) begin : g_bot_end
         assign prv_val = '0;
         assign prv_age = '0;
         assign prv_gt  = 1'b0;
      end else begin : g_bot_mid
         assign prv_val = c_val[i-1];
         assign prv_age = c_age[i-1];
         assign prv_gt  = c_gt[i-1];
      end

      smad_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .AGE_W        (AGE_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .sample    (req_sample),
         .age_last  (age_last),
         .own_valid (cell_valid[i]),
         .del_le    (del_le[i]),
         .nxt_val   (nxt_val),
         .nxt_age   (nxt_age),
         .nxt_gt    (nxt_gt),
         .nxt_valid (nxt_valid),
         .prv_c_val (prv_val),
         .prv_c_age (prv_age),
         .prv_c_gt  (prv_gt),
         .val       (cell_val[i]),
         .age       (c_age_raw[i]),
         .gt        (cell_gt[i]),
         .del       (cell_del[i]),
         .c_val     (c_val[i]),
         .c_age     (c_age[i]),
         .c_gt      (c_gt[i])
      );
   end

   // ---------------------------------------------------------------
   // deviation sum and median, two registered stages after the chain
   // ---------------------------------------------------------------
   smad_sum #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_sum (
      .clock         (clock),
      .load1         (adv1),
      .load2         (adv2),
      .cell_val      (cell_val),
      .win_len       (win_len),
      .deviation_sum (rsp_deviation_sum),
      .median_value  (rsp_median_value)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for the sliding median absolute deviation block
// needs smad_pkg and sliding_median_abs_deviation with its cells and adder tree

module testbench;

   import smad_pkg::*;

   localparam int WIN_MAX    = WINDOW_MAX_DEF;
   localparam int SMP_W      = SAMPLE_WIDTH_DEF;
   localparam int CYCLE_CAP  = 1_000_000;
   // register byte addresses: window_size, and one past the end of the list
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;
   // cycles allowed after the last result for items still inside the block
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;

   typedef struct packed {
      logic [DEV_W-1:0] dev;
      logic [SMP_W-1:0] med;
   } mad_result_t;

   // window model and store of expected results
   class median_dev_board;
      logic [SMP_W-1:0] win_val [WIN_MAX];
      int unsigned      win_age [WIN_MAX];
      int unsigned      filled;
      logic [CFG_W-1:0] size_reg;
      mad_result_t      pending_results [$];
      int               errors;

      function new();
         size_reg = WINDOW_SIZE_RST;
         filled   = 0;
         errors   = 0;
      endfunction

      // writing the size empties the window
      function void set_window(logic [CSR_DATA_W-1:0] value);
         size_reg = value[CFG_W-1:0];
         filled   = 0;
      endfunction

      function int unsigned span();
         if (size_reg == 0) return 1;
         if (size_reg > WIN_MAX) return WIN_MAX;
         return size_reg;
      endfunction

      function void note_sample(logic [SMP_W-1:0] s);
         int unsigned k, pos, oldest, i, total;
         logic [SMP_W-1:0] med;
         mad_result_t r;
         k = span();
         // oldest entry leaves once the window is full
         while (filled >= k && filled > 0) begin
            oldest = 0;
            for (i = 1; i < filled; i++)
               if (win_age[i] > win_age[oldest]) oldest = i;
            for (i = oldest; i + 1 < filled; i++) begin
               win_val[i] = win_val[i+1];
               win_age[i] = win_age[i+1];
            end
            filled--;
         end
         for (i = 0; i < filled; i++) win_age[i]++;
         // equal values keep oldest first, so the new one goes after them
         pos = 0;
         while (pos < filled && win_val[pos] <= s) pos++;
         for (i = filled; i > pos; i--) begin
            win_val[i] = win_val[i-1];
            win_age[i] = win_age[i-1];
         end
         win_val[pos] = s;
         win_age[pos] = 0;
         filled++;
         if (filled != k) return;
         med   = win_val[(k - 1) / 2];
         total = 0;
         for (i = 0; i < filled; i++)
            total += (win_val[i] >= med) ? win_val[i] - med : med - win_val[i];
         r.dev = total[DEV_W-1:0];
         r.med = med;
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [DEV_W-1:0] dev, logic [SMP_W-1:0] med);
         mad_result_t want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, deviation_sum %0d median_value %0d",
                     $time, dev, med);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (dev !== want.dev) begin
            $display("%0t: deviation_sum mismatch, expected %0d, actual %0d",
                     $time, want.dev, dev);
            errors++;
         end
         if (med !== want.med) begin
            $display("%0t: median_value mismatch, expected %0d, actual %0d",
                     $time, want.med, med);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SMP_W-1:0]      req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DEV_W-1:0]      rsp_deviation_sum;
   logic [SMP_W-1:0]      rsp_median_value;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   median_dev_board board = new();

   // calm and long_hold_request are shared between the sender and the receiver
   bit calm = 1'b0;               // no idling on either side
   bit long_hold_request = 1'b0;  // receiver holds off for a long stretch
   int hold_left = 0;
   int run_left  = 0;
   int unsigned cycle_count = 0;

   sliding_median_abs_deviation i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_deviation_sum (rsp_deviation_sum),
      .rsp_median_value  (rsp_median_value),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // zeros, full scale and small clusters give ties and large sums
   function automatic logic [SMP_W-1:0] pick_sample(bit extremes);
      int r;
      r = $urandom_range(0, 9);
      if (extremes) return r[0] ? '1 : '0;
      case (r)
         0:       return '0;
         1:       return '1;
         2, 3:    return SMP_W'($urandom_range(0, 7));
         4:       return SMP_W'(16'hFFFF - $urandom_range(0, 3));
         default: return SMP_W'($urandom());
      endcase
   endfunction

   // sampled before the edge updates anything, so the order of processes does not matter
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_sample(req_sample);
         if (rsp_valid && rsp_ready) board.check_result(rsp_deviation_sum, rsp_median_value);
      end
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (calm || run_left > 0) begin
            rsp_ready <= 1'b1;
            if (run_left > 0) run_left--;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_ready <= 1'b1;
               run_left = $urandom_range(0, 6);
            end else begin
               rsp_ready <= 1'b0;
               hold_left = gap - 1;
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_CAP) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // offer one item after an optional gap and wait for it to be taken
   task automatic send_sample(input logic [SMP_W-1:0] s, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering and let every expected result come out, then let the pipe empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // addresses past the register list are ignored by the block
      if (addr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE) board.set_window(data);
   endtask

   task automatic csr_check_size(input logic [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_WINDOW_SIZE;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got[CFG_W-1:0] !== want) begin
         $display("%0t: window_size readback mismatch, expected %0d, actual %0d",
                  $time, want, got[CFG_W-1:0]);
         board.errors++;
      end
   endtask

   // size change: drain first, upper data bits are junk the register drops
   task automatic set_size(input logic [CFG_W-1:0] size);
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      data = ($urandom() & ~CSR_DATA_W'(7'h7F)) | CSR_DATA_W'(size);
      csr_write(ADDR_WINDOW_SIZE, data);
      csr_check_size(size);
   endtask

   initial begin
      int phase_size [14] = '{64, 2, 0, 100, 7, 127, 33, 4, 1, 16, 63, 5, 0, 0};
      int unsigned k, n, idx;
      bit extremes;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: window of one after reset, every item a zero sum
      send_sample(16'h0000, pick_gap());
      send_sample(16'hFFFF, pick_gap());
      send_sample(16'hFFFF, 0);
      send_sample(16'h0001, 0);
      send_sample(16'h8000, pick_gap());
      send_sample(16'h0000, 0);

      // even window, lower median picks the smaller value
      set_size(7'd2);
      send_sample(16'hFFFF, 0);
      send_sample(16'h0000, pick_gap());
      send_sample(16'h0000, 0);
      send_sample(16'hFFFF, 0);

      // ties: equal values leave oldest first
      set_size(7'd3);
      send_sample(16'd7, 0);
      send_sample(16'd7, 0);
      send_sample(16'd7, pick_gap());
      // write past the register list, window must carry on untouched
      wait_idle();
      csr_write(ADDR_UNMAPPED, 32'h0000_0005);
      send_sample(16'd3, 0);
      send_sample(16'd9, 0);
      send_sample(16'd7, pick_gap());
      send_sample(16'hFFFF, 0);

      // size zero behaves as one
      set_size(7'd0);
      send_sample(16'h1234, 0);
      send_sample(16'hFFFF, pick_gap());
      send_sample(16'h0000, 0);

      // random phases over a spread of sizes, saturating ones among them
      for (int phase = 0; phase < 14; phase++) begin
         if (phase >= 12) phase_size[phase] = $urandom_range(1, WIN_MAX);
         set_size(CFG_W'(phase_size[phase]));
         k = board.span();
         n = k - 1 + $urandom_range(30, 70);
         extremes = (phase == 3);
         calm = (phase == 6) || ($urandom_range(0, 5) == 0);
         for (idx = 0; idx < n; idx++) begin
            // fill the block while the result side stalls
            if (phase == 9 && idx == k + 5) long_hold_request = 1'b1;
            if (idx == n / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) wait_idle();
            send_sample(pick_sample(extremes),
                        (calm || phase == 9) ? 0 : pick_gap());
         end
         calm = 1'b0;
      end

      wait_idle();
      if (board.pending_results.size() != 0) begin
         $display("%0t: %0d expected results never came", $time,
                  board.pending_results.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/smad_pkg.sv
sv/smad_cell.sv
sv/smad_sum.sv
sv/sliding_median_abs_deviation.sv
test/testbench.sv
